/* hdl/assert_macros.svh */
// Assertion macros shared by the registry RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHAR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("registry check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define SHAR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("registry check failed: next-cycle implication");

`endif

/* hdl/shar_pkg.sv */
// Shared types and constants of the short handle address registry.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package shar_pkg;

	// Fixed field widths of the stream beats.
	localparam int FUNC_W       = 2;
	localparam int ADDR_FIELD_W = 64;
	localparam int KEY_FIELD_W  = 32;
	localparam int OFFS_FIELD_W = 16;
	localparam int STATUS_W     = 2;
	localparam int SLOT_FIELD_W = 6;

	// Input beat layout, lowest bit first, padded to whole bytes.
	localparam int IN_FUNC_LSB  = 0;
	localparam int IN_ADDR_LSB  = IN_FUNC_LSB + FUNC_W;
	localparam int IN_KEY_LSB   = IN_ADDR_LSB + ADDR_FIELD_W;
	localparam int IN_OFFS_LSB  = IN_KEY_LSB + KEY_FIELD_W;
	localparam int IN_USED_W    = IN_OFFS_LSB + OFFS_FIELD_W;
	localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

	// Output beat layout, lowest bit first, padded to whole bytes.
	localparam int OUT_USED_W   = STATUS_W + ADDR_FIELD_W + KEY_FIELD_W + OFFS_FIELD_W
		+ SLOT_FIELD_W;
	localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

	// Request codes.
	localparam logic [FUNC_W-1:0] FUNC_REGISTER   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_UNREGISTER = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ADDR2KEY   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_KEY2ADDR   = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BAD_KEY   = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the accepted request beat
		logic rd_en;   // read the table entry at the index
		logic clear;   // write an empty entry at the index
		logic commit;  // resolve the request, update the table, load the result
	} shar_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;  // the result register can take a new beat this cycle
		logic out_busy;  // the result register holds a beat
	} shar_stat_t;

endpackage

`default_nettype wire

/* hdl/shar_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; used by the registry datapath for the entry table.
`default_nettype none

module shar_ram #(
	parameter int WIDTH = 81,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* hdl/shar_ctrl.sv */
// Controller of the registry: clearing pass, table scan sequencing and commit.
// Depends on shar_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module shar_ctrl import shar_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire shar_stat_t                       stat,
	output shar_cmd_t                             cmd,
	output logic      [$clog2(TABLE_ENTRIES)-1:0] idx
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_LAST   = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic             at_last;

	assign at_last  = (cnt_q == LAST_IDX);
	assign s_tready = (state_q == S_IDLE);
	assign idx      = cnt_q;

	// Commands decoded from the state.
	always_comb begin
		cmd.load   = s_tvalid && (state_q == S_IDLE);
		cmd.rd_en  = (state_q == S_SCAN);
		cmd.clear  = (state_q == S_CLEAR);
		cmd.commit = (state_q == S_COMMIT) && stat.out_free;
	end

	// State register and entry counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (at_last) begin
						state_q <= S_IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
					end
				end
				S_SCAN: begin
					if (at_last) begin
						state_q <= S_LAST;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_LAST: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// A result is only committed when the output register can take it.
	`SHAR_ASSERT_SAME(a_commit_out_free, cmd.commit, stat.out_free)
	// An accepted beat always starts a scan at the first entry.
	`SHAR_ASSERT_NEXT(a_load_starts_scan, cmd.load, (state_q == S_SCAN) && (cnt_q == '0))
	// The drain cycle directly follows the read of the final entry.
	`SHAR_ASSERT_NEXT(a_scan_drains, cmd.rd_en && at_last, state_q == S_LAST)
	// A commit always leaves a beat in the output register.
	`SHAR_ASSERT_NEXT(a_commit_fills_out, cmd.commit, stat.out_busy)

endmodule

`default_nettype wire

/* hdl/shar_dpath.sv */
// Datapath of the registry: request capture, entry table, scan trackers, result register.
// Depends on shar_pkg and shar_ram.
`default_nettype none

module shar_dpath import shar_pkg::*; #(
	parameter int TABLE_ENTRIES = 64,
	parameter int ADDRESS_BITS  = 64,
	parameter int KEY_BITS      = 32,
	parameter int OFFSET_BITS   = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire shar_cmd_t                        cmd,
	output shar_stat_t                            stat,
	input  wire logic [$clog2(TABLE_ENTRIES)-1:0] idx,
	input  wire logic [IN_TDATA_W-1:0]            s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [OUT_TDATA_W-1:0]           m_tdata
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int RAM_W = 1 + OFFSET_BITS + ADDRESS_BITS;
	localparam logic [ADDR_FIELD_W-1:0] KEY_MASK = (KEY_BITS >= ADDR_FIELD_W) ?
		{ADDR_FIELD_W{1'b1}} : ((ADDR_FIELD_W'(1) << KEY_BITS) - ADDR_FIELD_W'(1));

	// Captured request.
	logic [FUNC_W-1:0]       func_q;
	logic [ADDRESS_BITS-1:0] addr_q;
	logic [KEY_FIELD_W-1:0]  key_q;
	logic [OFFSET_BITS-1:0]  offs_q;

	// Scan trackers.
	logic                    eval_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    found_q;
	logic                    dup_q;
	logic [IDX_W-1:0]        slot_q;
	logic [ADDRESS_BITS-1:0] hit_addr_q;
	logic [OFFSET_BITS-1:0]  hit_offs_q;

	// Table port.
	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [RAM_W-1:0]        ram_wdata;
	logic [RAM_W-1:0]        ram_rdata;
	logic                    rd_valid;
	logic [ADDRESS_BITS-1:0] rd_addr;
	logic [OFFSET_BITS-1:0]  rd_offs;

	// Per-entry compare results.
	logic [ADDR_FIELD_W-1:0] req_handle;
	logic [ADDR_FIELD_W-1:0] rd_handle;
	logic                    key_dup;
	logic                    entry_hit;

	// Result of the commit cycle.
	logic [STATUS_W-1:0]     res_status;
	logic [ADDR_FIELD_W-1:0] res_addr;
	logic [KEY_FIELD_W-1:0]  res_handle;
	logic [OFFS_FIELD_W-1:0] res_offs;
	logic [SLOT_FIELD_W-1:0] res_slot;
	logic                    res_write;
	logic                    res_remove;

	// Output register.
	logic                    out_valid_q;
	logic [STATUS_W-1:0]     out_status_q;
	logic [ADDR_FIELD_W-1:0] out_addr_q;
	logic [KEY_FIELD_W-1:0]  out_handle_q;
	logic [OFFS_FIELD_W-1:0] out_offs_q;
	logic [SLOT_FIELD_W-1:0] out_slot_q;

	// Capture the request fields of an accepted beat.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= s_tdata[IN_FUNC_LSB +: FUNC_W];
			addr_q <= s_tdata[IN_ADDR_LSB +: ADDRESS_BITS];
			key_q  <= s_tdata[IN_KEY_LSB +: KEY_FIELD_W];
			offs_q <= OFFSET_BITS'(s_tdata[IN_OFFS_LSB +: OFFS_FIELD_W]);
		end
	end

	// Entry table: valid flag, offset and address in one word.
	shar_ram #(
		.WIDTH(RAM_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx),
		.rdata(ram_rdata)
	);

	assign rd_valid = ram_rdata[RAM_W-1];
	assign rd_offs  = ram_rdata[ADDRESS_BITS +: OFFSET_BITS];
	assign rd_addr  = ram_rdata[ADDRESS_BITS-1:0];

	// Compare the entry read last cycle against the request.
	always_comb begin
		req_handle = KEY_MASK & ADDR_FIELD_W'(addr_q);
		rd_handle  = KEY_MASK & ADDR_FIELD_W'(rd_addr);
		key_dup    = rd_valid && (rd_handle == req_handle);
		if (func_q == FUNC_KEY2ADDR) begin
			entry_hit = rd_valid && (rd_handle == ADDR_FIELD_W'(key_q));
		end else begin
			entry_hit = rd_valid && (rd_addr == addr_q);
		end
	end

	// Read pipeline tag, aligned with the registered read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1 <= 1'b0;
		end else begin
			eval_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
	end

	// Trackers: duplicate key, lowest free slot, first matching entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			dup_q   <= 1'b0;
		end else if (cmd.load) begin
			found_q <= 1'b0;
			dup_q   <= 1'b0;
		end else if (eval_s1) begin
			if (func_q == FUNC_REGISTER) begin
				if (key_dup) begin
					dup_q <= 1'b1;
				end
				if (!rd_valid && !found_q) begin
					found_q <= 1'b1;
				end
			end else if (entry_hit && !found_q) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval_s1 && !found_q) begin
			if (func_q == FUNC_REGISTER) begin
				if (!rd_valid) begin
					slot_q <= idx_s1;
				end
			end else if (entry_hit) begin
				slot_q     <= idx_s1;
				hit_addr_q <= rd_addr;
				hit_offs_q <= rd_offs;
			end
		end
	end

	// Resolve the request once every entry has been seen.
	always_comb begin
		res_status = STAT_NOT_FOUND;
		res_addr   = '0;
		res_handle = '0;
		res_offs   = '0;
		res_slot   = '0;
		res_write  = 1'b0;
		res_remove = 1'b0;
		if (func_q == FUNC_REGISTER) begin
			if ((req_handle == '0) || dup_q) begin
				res_status = STAT_BAD_KEY;
			end else if (!found_q) begin
				res_status = STAT_FULL;
			end else begin
				res_status = STAT_OK;
				res_addr   = ADDR_FIELD_W'(addr_q);
				res_handle = req_handle[KEY_FIELD_W-1:0];
				res_slot   = SLOT_FIELD_W'(slot_q);
				res_write  = 1'b1;
			end
		end else if (found_q) begin
			res_status = STAT_OK;
			res_addr   = ADDR_FIELD_W'(hit_addr_q);
			res_handle = KEY_FIELD_W'(KEY_MASK & ADDR_FIELD_W'(hit_addr_q));
			res_slot   = SLOT_FIELD_W'(slot_q);
			if (func_q == FUNC_UNREGISTER) begin
				res_offs   = OFFS_FIELD_W'(hit_offs_q);
				res_remove = 1'b1;
			end
		end
	end

	// Table writes: clearing pass, new entry or removal.
	always_comb begin
		ram_we    = cmd.clear || (cmd.commit && (res_write || res_remove));
		ram_waddr = cmd.clear ? idx : slot_q;
		ram_wdata = (cmd.clear || res_remove) ? '0 : {1'b1, offs_q, addr_q};
	end

	// Output register, refilled only when empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q <= res_status;
			out_addr_q   <= res_addr;
			out_handle_q <= res_handle;
			out_offs_q   <= res_offs;
			out_slot_q   <= res_slot;
		end
	end

	assign stat.out_free = !out_valid_q || m_tready;
	assign stat.out_busy = out_valid_q;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = OUT_TDATA_W'({out_slot_q, out_offs_q, out_handle_q, out_addr_q,
		out_status_q});

endmodule

`default_nettype wire

/* hdl/short_handle_address_registry_unit.sv */
// Short handle address registry: each request scans the whole table, one entry per cycle.
// An accepted beat is followed by the scan, a drain state and a commit that waits until
// the output register is free; a new request is taken only after the previous commit.
// Reset: arst_n clears control state, then a clearing pass writes an empty entry at every
// index to empty the table; s_tready stays low until it ends.
// Depends on shar_pkg, shar_ctrl, shar_dpath and shar_ram.
`default_nettype none

module short_handle_address_registry_unit import shar_pkg::*; #(
	parameter int TABLE_ENTRIES = 64,
	parameter int ADDRESS_BITS  = 64,
	parameter int KEY_BITS      = 32,
	parameter int OFFSET_BITS   = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// func[1:0], full_address[65:2], short_handle[97:66], base_offset[113:98], zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// status[1:0], address_out[65:2], handle_out[97:66], offset_out[113:98],
	// slot_out[119:114]
	output logic      [OUT_TDATA_W-1:0] m_tdata
);

	shar_cmd_t                          cmd;
	shar_stat_t                         stat;
	logic [$clog2(TABLE_ENTRIES)-1:0]   idx;

	// Sequencer for clearing, scanning and committing.
	shar_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd),
		.idx     (idx)
	);

	// Table, compare logic and result register.
	shar_dpath #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.ADDRESS_BITS (ADDRESS_BITS),
		.KEY_BITS     (KEY_BITS),
		.OFFSET_BITS  (OFFSET_BITS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.idx     (idx),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

`default_nettype wire
